FILE: rtl/core/rfc_pkg.sv
// Shared types, codes and widths for the reply frame checker.
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

  // Parse phase codes.
  localparam logic [1:0] PHASE_HUNT = 2'd0;
  localparam logic [1:0] PHASE_LEN  = 2'd1;
  localparam logic [1:0] PHASE_BODY = 2'd2;

  // Frame status codes.
  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_ACCEPT  = 2'd1;
  localparam logic [1:0] STATUS_REJECT  = 2'd2;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_DEVICE  = 2'd1;
  localparam logic [1:0] REG_COMMAND = 2'd2;

  localparam int unsigned AddrWidth = 4;
  localparam logic [7:0] FlagBit    = 8'h80;
  localparam logic [7:0] MinLength  = 8'd4;

  // Configuration register values.
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] device_address;
    logic [7:0] command_id;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [1:0] frame_status;
    logic [7:0] frame_length;
    logic       echo_flagged;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rfc_apb_regs.sv
// APB configuration registers of the reply frame checker.
`timescale 1ns / 1ps
`default_nettype none

module rfc_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rfc_pkg::AddrWidth-1:0]   paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output rfc_pkg::cfg_t                        cfg_o
);

  rfc_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        rfc_pkg::REG_HEADER:  cfg_d.header_byte    = pwdata[7:0];
        rfc_pkg::REG_DEVICE:  cfg_d.device_address = pwdata[7:0];
        rfc_pkg::REG_COMMAND: cfg_d.command_id     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      rfc_pkg::REG_HEADER:  prdata = {24'd0, cfg_q.header_byte};
      rfc_pkg::REG_DEVICE:  prdata = {24'd0, cfg_q.device_address};
      rfc_pkg::REG_COMMAND: prdata = {24'd0, cfg_q.command_id};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/rfc_parser.sv
// Frame parse state and the per-byte step logic.
`timescale 1ns / 1ps
`default_nettype none

module rfc_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             clear_frame_i,
  input  rfc_pkg::cfg_t         cfg_i,
  output rfc_pkg::result_t      result_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] exp_len_q, exp_len_d;
  logic [7:0] index_q, index_d;
  logic [7:0] sum_q, sum_d;
  logic       addr_ok_q, addr_ok_d;
  logic       cmd_ok_q, cmd_ok_d;
  logic       flagged_q, flagged_d;

  // State as seen after an optional clear.
  logic [1:0] phase_c;
  logic [7:0] exp_len_c, index_c, sum_c;
  logic       addr_ok_c, cmd_ok_c, flagged_c;

  logic [7:0] marked_cmd;
  logic [8:0] index_next;
  logic       last_byte;
  logic       frame_ok;

  always_comb begin
    if (clear_frame_i) begin
      phase_c   = rfc_pkg::PHASE_HUNT;
      exp_len_c = '0;
      index_c   = '0;
      sum_c     = '0;
      addr_ok_c = 1'b0;
      cmd_ok_c  = 1'b0;
      flagged_c = 1'b0;
    end else begin
      phase_c   = phase_q;
      exp_len_c = exp_len_q;
      index_c   = index_q;
      sum_c     = sum_q;
      addr_ok_c = addr_ok_q;
      cmd_ok_c  = cmd_ok_q;
      flagged_c = flagged_q;
    end
  end

  assign marked_cmd = cfg_i.command_id | rfc_pkg::FlagBit;
  assign index_next = {1'b0, index_c} + 9'd1;
  assign last_byte  = index_next >= {1'b0, exp_len_c};
  assign frame_ok   = addr_ok_c && cmd_ok_c && (rx_byte_i == sum_c);

  // One parse step for the byte in hand.
  always_comb begin
    phase_d   = phase_c;
    exp_len_d = exp_len_c;
    index_d   = index_c;
    sum_d     = sum_c;
    addr_ok_d = addr_ok_c;
    cmd_ok_d  = cmd_ok_c;
    flagged_d = flagged_c;
    result_o  = '0;
    unique case (phase_c)
      rfc_pkg::PHASE_HUNT: begin
        if (rx_byte_i == cfg_i.header_byte) begin
          phase_d = rfc_pkg::PHASE_LEN;
        end
      end
      rfc_pkg::PHASE_LEN: begin
        if (rx_byte_i < rfc_pkg::MinLength) begin
          // Short length: drop, but the byte may itself be a new header.
          result_o.frame_status = rfc_pkg::STATUS_BAD_LEN;
          result_o.frame_length = rx_byte_i;
          phase_d   = (rx_byte_i == cfg_i.header_byte) ? rfc_pkg::PHASE_LEN
                                                       : rfc_pkg::PHASE_HUNT;
          exp_len_d = '0;
          index_d   = '0;
          sum_d     = '0;
          addr_ok_d = 1'b0;
          cmd_ok_d  = 1'b0;
          flagged_d = 1'b0;
        end else begin
          exp_len_d = rx_byte_i;
          sum_d     = rx_byte_i;
          index_d   = 8'd1;
          addr_ok_d = 1'b0;
          cmd_ok_d  = 1'b0;
          flagged_d = 1'b0;
          phase_d   = rfc_pkg::PHASE_BODY;
        end
      end
      rfc_pkg::PHASE_BODY: begin
        if (last_byte) begin
          // Checksum byte closes the frame.
          result_o.frame_status = frame_ok ? rfc_pkg::STATUS_ACCEPT
                                           : rfc_pkg::STATUS_REJECT;
          result_o.frame_length = exp_len_c;
          result_o.echo_flagged = frame_ok && flagged_c;
          phase_d   = rfc_pkg::PHASE_HUNT;
          exp_len_d = '0;
          index_d   = '0;
          sum_d     = '0;
          addr_ok_d = 1'b0;
          cmd_ok_d  = 1'b0;
          flagged_d = 1'b0;
        end else begin
          if (index_c == 8'd1) begin
            addr_ok_d = (rx_byte_i == cfg_i.device_address);
          end else if (index_c == 8'd2) begin
            cmd_ok_d  = (rx_byte_i == cfg_i.command_id) || (rx_byte_i == marked_cmd);
            flagged_d = (rx_byte_i != cfg_i.command_id) && (rx_byte_i == marked_cmd);
          end
          sum_d   = sum_c + rx_byte_i;
          index_d = index_next[7:0];
        end
      end
      default: begin
        phase_d = rfc_pkg::PHASE_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rfc_pkg::PHASE_HUNT;
      exp_len_q <= '0;
      index_q   <= '0;
      sum_q     <= '0;
      addr_ok_q <= 1'b0;
      cmd_ok_q  <= 1'b0;
      flagged_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      exp_len_q <= exp_len_d;
      index_q   <= index_d;
      sum_q     <= sum_d;
      addr_ok_q <= addr_ok_d;
      cmd_ok_q  <= cmd_ok_d;
      flagged_q <= flagged_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/reply_frame_checker.sv
// Reply frame checker: input word register, parse step and result register.
// A word waits in the input word register; its parse result then enters the result register.
// Throughput: one word per cycle while m_axis_tready is high; parsing is a compare and an 8-bit add.
// Both the input and the result register move whenever the next stage frees up.
// Reset (rst_ni low, asynchronous) empties both registers, returns the parser to
// header hunting and clears all configuration registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module reply_frame_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                          s_axis_tuser,  // [0] clear_frame
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [15:0]                   m_axis_tdata,  // [7:0] frame_length,
                                                            // [8] echo_flagged, rest 0
  output logic      [1:0]                    m_axis_tuser,  // [1:0] frame_status
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rfc_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  rfc_pkg::cfg_t    cfg;
  rfc_pkg::result_t step_res;
  rfc_pkg::result_t res_q;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_clear_q;
  logic       out_valid_q;
  logic       out_free;
  logic       step;

  rfc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake between the two registers.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  // Input word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_clear_q <= s_axis_tuser;
    end
  end

  rfc_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (in_byte_q),
    .clear_frame_i (in_clear_q),
    .cfg_i         (cfg),
    .result_o      (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.echo_flagged, res_q.frame_length};
  assign m_axis_tuser  = res_q.frame_status;

`ifndef SYNTH
  // An idle result carries no length and no echo flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == rfc_pkg::STATUS_NONE) |-> (m_axis_tdata == 16'd0))
    else $error("idle result carries nonzero data");

  // Echo flag only on accepted frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tuser == rfc_pkg::STATUS_ACCEPT))
    else $error("echo flag without accepted frame");

  // A dropped length is always short, a completed frame never.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == rfc_pkg::STATUS_BAD_LEN)
      |-> (m_axis_tdata[7:0] < rfc_pkg::MinLength))
    else $error("bad length status with valid length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == rfc_pkg::STATUS_ACCEPT ||
                       m_axis_tuser == rfc_pkg::STATUS_REJECT))
      |-> (m_axis_tdata[7:0] >= rfc_pkg::MinLength))
    else $error("completed frame with short length");

  // A held input word steps as soon as the result register frees up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> step)
    else $error("pending word not stepped into empty result register");
`endif

endmodule

`default_nettype wire

FILE: sim/reply_frame_checker_tb.sv
// Self-checking testbench for the reply frame checker: directed frames, then random traffic.
`timescale 1ns / 1ps

module reply_frame_checker_tb;

  localparam time HalfPeriod = 5ns;
  localparam int  ResetCycles = 10;
  localparam int  CycleLimit = 200000;
  localparam int  DrainCycles = 4;
  localparam int  RandomPhases = 8;
  localparam int  WordsPerPhase = 80;

  typedef enum int {
    RX_ALWAYS,
    RX_PERIODIC,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  // Block ports; the inputs are driven to known values from time zero.
  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata = '0;   // [7:0] rx_byte
  logic                          s_axis_tuser = 1'b0; // [0] clear_frame
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;        // [7:0] frame_length, [8] echo_flagged
  logic [1:0]                    m_axis_tuser;        // [1:0] frame_status
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [rfc_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  reply_frame_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Register values and parser state as the block should hold them.
  rfc_pkg::cfg_t cfg;
  logic [1:0]    trk_phase;
  logic [7:0]    trk_len;
  logic [7:0]    trk_idx;
  logic [7:0]    trk_sum;
  logic          addr_ok;
  logic          cmd_ok;
  logic          flagged;

  rfc_pkg::result_t pending_results[$];
  rfc_pkg::result_t want_res;
  logic [7:0]       frame_payload[$];
  int               mismatches = 0;
  int               frame_words = 0;
  int               burst_left = 0;
  int               cycles = 0;
  int               rx_cycle = 0;
  rx_mode_e         rx_mode = RX_ALWAYS;

  function automatic void restart_hunt();
    trk_phase = rfc_pkg::PHASE_HUNT;
    trk_len   = '0;
    trk_idx   = '0;
    trk_sum   = '0;
    addr_ok   = 1'b0;
    cmd_ok    = 1'b0;
    flagged   = 1'b0;
  endfunction

  // Advances the parser by one received byte and returns the result word it gives.
  function automatic rfc_pkg::result_t parse_byte(input logic [7:0] rx, input logic clr);
    rfc_pkg::result_t r;
    logic             ok;
    r = '0;
    r.frame_status = rfc_pkg::STATUS_NONE;
    if (clr) restart_hunt();
    case (trk_phase)
      rfc_pkg::PHASE_HUNT: begin
        if (rx == cfg.header_byte) trk_phase = rfc_pkg::PHASE_LEN;
      end
      rfc_pkg::PHASE_LEN: begin
        if (rx < rfc_pkg::MinLength) begin
          r.frame_status = rfc_pkg::STATUS_BAD_LEN;
          r.frame_length = rx;
          restart_hunt();
          // A short length byte that equals the header opens a new frame.
          if (rx == cfg.header_byte) trk_phase = rfc_pkg::PHASE_LEN;
        end else begin
          trk_len   = rx;
          trk_sum   = rx;
          trk_idx   = 8'd1;
          addr_ok   = 1'b0;
          cmd_ok    = 1'b0;
          flagged   = 1'b0;
          trk_phase = rfc_pkg::PHASE_BODY;
        end
      end
      default: begin
        if (int'(trk_idx) + 1 >= int'(trk_len)) begin
          // Checksum byte closes the frame.
          ok = addr_ok && cmd_ok && (rx == trk_sum);
          r.frame_status = ok ? rfc_pkg::STATUS_ACCEPT : rfc_pkg::STATUS_REJECT;
          r.frame_length = trk_len;
          r.echo_flagged = ok && flagged;
          restart_hunt();
        end else begin
          if (trk_idx == 8'd1) begin
            addr_ok = (rx == cfg.device_address);
          end else if (trk_idx == 8'd2) begin
            cmd_ok  = (rx == cfg.command_id) || (rx == (cfg.command_id | rfc_pkg::FlagBit));
            flagged = (rx != cfg.command_id) && (rx == (cfg.command_id | rfc_pkg::FlagBit));
          end
          trk_sum = trk_sum + rx;
          trk_idx = trk_idx + 8'd1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic pick_clear(input int odds);
    return (odds != 0) && ($urandom_range(0, odds - 1) == 0);
  endfunction

  // Holds the input side idle; n sets how long.
  task automatic pause_input(input int n);
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Sends one word, in bursts of random length with random gaps between them.
  task automatic send_word(input logic [7:0] rx, input logic clr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) pause_input(gap);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= clr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(parse_byte(rx, clr));
  endtask

  // Sends header, length, address, command, frame_payload and checksum.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] addr,
                            input logic [7:0] cmd, input bit bad_sum, input int clr_odds);
    logic [7:0] sum;
    sum = len + addr + cmd;
    foreach (frame_payload[i]) sum = sum + frame_payload[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_word(cfg.header_byte, pick_clear(clr_odds));
    send_word(len, pick_clear(clr_odds));
    send_word(addr, pick_clear(clr_odds));
    send_word(cmd, pick_clear(clr_odds));
    foreach (frame_payload[i]) send_word(frame_payload[i], pick_clear(clr_odds));
    send_word(sum, pick_clear(clr_odds));
    frame_words += int'(len) + 1;
  endtask

  // Waits until every expected result has come back and the pipeline is empty.
  task automatic settle();
    pause_input(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (rfc_pkg::AddrWidth)'({idx, 2'b00});
    pwdata  <= {24'($urandom_range(0, 32'hFF_FFFF)), value};
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      rfc_pkg::REG_HEADER:  cfg.header_byte = value;
      rfc_pkg::REG_DEVICE:  cfg.device_address = value;
      rfc_pkg::REG_COMMAND: cfg.command_id = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_config(input logic [7:0] hdr, input logic [7:0] dev,
                              input logic [7:0] cmd);
    settle();
    write_reg(rfc_pkg::REG_HEADER, hdr);
    write_reg(rfc_pkg::REG_DEVICE, dev);
    write_reg(rfc_pkg::REG_COMMAND, cmd);
  endtask

  // All registers are zero after reset: header 0, and command 0 in flagged form.
  task automatic test_reset_values();
    frame_payload = {};
    send_frame(8'h04, 8'h00, 8'h80, 1'b0, 0);
  endtask

  // Accepted frame, header value inside a rejected frame, and a short length.
  task automatic test_basic_frames();
    write_config(8'hA5, 8'h12, 8'h33);
    frame_payload = {};
    send_frame(8'h04, 8'h12, 8'h33, 1'b0, 0);
    frame_payload = {8'hA5};
    send_frame(8'h05, 8'h13, 8'h33, 1'b0, 0);
    send_word(8'hA5, 1'b0);
    send_word(8'h01, 1'b0);
  endtask

  // A clear mid-frame drops it, and the same word starts a flagged frame.
  task automatic test_clear_restart();
    send_word(8'hA5, 1'b0);
    send_word(8'h06, 1'b0);
    send_word(8'h12, 1'b0);
    send_word(8'hA5, 1'b1);
    send_word(8'h04, 1'b0);
    send_word(8'h12, 1'b0);
    send_word(8'hB3, 1'b0);
    send_word(8'hC9, 1'b0);
  endtask

  // Short length equal to the header reopens a frame; command id with bit 7 already set.
  task automatic test_short_length_header();
    write_config(8'h03, 8'hFF, 8'h80);
    send_word(8'h03, 1'b0);
    send_word(8'h03, 1'b0);
    send_word(8'h04, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h83, 1'b0);
    frame_payload = {};
    send_frame(8'h04, 8'hFF, 8'h00, 1'b0, 0);
  endtask

  // One random frame, mostly well formed, sometimes short or broken, or one to four noise words instead.
  task automatic random_frame();
    int         pick;
    int         len;
    logic [7:0] addr;
    logic [7:0] cmd;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)), pick_clear(8));
      return;
    end
    pick = $urandom_range(0, 59);
    if (pick < 3) begin
      send_word(cfg.header_byte, pick_clear(10));
      send_word(8'($urandom_range(0, 3)), 1'b0);
      frame_words += 2;
      return;
    end
    if (pick == 3) len = ($urandom_range(0, 1) == 0) ? 255 : $urandom_range(100, 254);
    else len = $urandom_range(4, 12);
    addr = ($urandom_range(0, 3) != 0) ? cfg.device_address : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: cmd = cfg.command_id;
      1: cmd = cfg.command_id | rfc_pkg::FlagBit;
      default: cmd = 8'($urandom_range(0, 255));
    endcase
    frame_payload = {};
    repeat (len - 4) begin
      frame_payload.push_back(($urandom_range(0, 7) == 0) ? cfg.header_byte
                                                          : 8'($urandom_range(0, 255)));
    end
    send_frame(8'(len), addr, cmd, $urandom_range(0, 7) == 0, 64);
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int p = 0; p < RandomPhases; p++) begin
      write_config(pick_byte(), pick_byte(), pick_byte());
      goal = frame_words + WordsPerPhase;
      while (frame_words < goal) random_frame();
    end
  endtask

  // Receiver ready pattern in one of four modes, each picked at random.
  always @(negedge clk_i) begin
    if (rx_cycle % 128 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    rx_cycle++;
    case (rx_mode)
      RX_ALWAYS:   m_axis_tready <= 1'b1;
      RX_PERIODIC: m_axis_tready <= (rx_cycle % 5) != 0;
      RX_RANDOM:   m_axis_tready <= $urandom_range(0, 2) != 0;
      default:     m_axis_tready <= (rx_cycle % 8) < 2;
    endcase
  end

  // Compares each result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got status %0d length %0d echo %0d",
                 $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8]);
      end else begin
        want_res = pending_results.pop_front();
        if (m_axis_tuser !== want_res.frame_status) begin
          mismatches++;
          $display("%0t: frame_status expected %0d, got %0d",
                   $time, want_res.frame_status, m_axis_tuser);
        end
        if (m_axis_tdata[7:0] !== want_res.frame_length) begin
          mismatches++;
          $display("%0t: frame_length expected %0d, got %0d",
                   $time, want_res.frame_length, m_axis_tdata[7:0]);
        end
        if (m_axis_tdata[8] !== want_res.echo_flagged) begin
          mismatches++;
          $display("%0t: echo_flagged expected %0d, got %0d",
                   $time, want_res.echo_flagged, m_axis_tdata[8]);
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("** reply_frame_checker: FAILED **");
      $finish;
    end
  end

  initial begin
    cfg = '0;
    restart_hunt();
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_reset_values();
    test_basic_frames();
    test_clear_restart();
    test_short_length_header();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("** reply_frame_checker: PASSED **");
    end else begin
      $display("** reply_frame_checker: FAILED **");
    end
    $finish;
  end

endmodule
